### src/tptm_pkg.sv
// Shared widths, codes, types and the square-root step for the track pair matcher.
package tptm_pkg;

	// field and datapath widths
	localparam int POS_W      = 23;
	localparam int SLP_W      = 20;
	localparam int DPOS_W     = POS_W + 1;
	localparam int DSLP_W     = SLP_W + 1;
	localparam int PROD_W     = DPOS_W + SLP_W;
	localparam int APROD_W    = DSLP_W + SLP_W;
	localparam int PROJ_W     = PROD_W + 1;
	localparam int APROJ_W    = APROD_W + 1;
	localparam int SQ_W       = 2 * SLP_W;
	localparam int ANG_W      = SQ_W / 2;
	localparam int ANG_OUT_W  = 19;
	localparam int SQ_STAGES  = SQ_W / 4;
	localparam int REM_W      = ANG_W + 4;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int MUL_W      = CFG_W + ANG_W;
	localparam int LIM_W      = ANG_W + 1;
	localparam int LT_W       = LIM_W + ANG_W;
	localparam int NTEST      = 4;
	localparam int CODE_W     = 3;
	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 24;

	// above this angle the differences are projected on the track direction
	localparam logic [ANG_W-1:0] ANGLE_STEEP = ANG_W'(655);

	// slot of each tolerance test, in test order
	typedef enum logic [1:0] {
		TST_PR = 2'd0,
		TST_PL = 2'd1,
		TST_AR = 2'd2,
		TST_AL = 2'd3
	} test_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_LAT_BASE  = 3'd0,
		REG_POS_LAT_SLOPE = 3'd1,
		REG_POS_RAD_BASE  = 3'd2,
		REG_POS_RAD_SLOPE = 3'd3,
		REG_ANG_LAT_BASE  = 3'd4,
		REG_ANG_LAT_SLOPE = 3'd5,
		REG_ANG_RAD_BASE  = 3'd6,
		REG_ANG_RAD_SLOPE = 3'd7
	} reg_idx_t;

	// result codes
	typedef enum logic [CODE_W-1:0] {
		FAIL_NONE    = 3'd0,
		FAIL_POS_RAD = 3'd1,
		FAIL_POS_LAT = 3'd2,
		FAIL_ANG_RAD = 3'd3,
		FAIL_ANG_LAT = 3'd4
	} fail_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pred_x;
		logic signed [POS_W-1:0] pred_y;
		logic signed [SLP_W-1:0] pred_ax;
		logic signed [SLP_W-1:0] pred_ay;
		logic signed [POS_W-1:0] cand_x;
		logic signed [POS_W-1:0] cand_y;
		logic signed [SLP_W-1:0] cand_ax;
		logic signed [SLP_W-1:0] cand_ay;
	} trk_pair_t;

	// projected magnitudes and raw difference magnitudes, per test slot
	typedef struct packed {
		logic [NTEST-1:0][PROJ_W-1:0] prj;
		logic [NTEST-1:0][DPOS_W-1:0] flat;
	} proj_t;

	typedef struct packed {
		logic [NTEST-1:0][CFG_W-1:0] base;
		logic [NTEST-1:0][CFG_W-1:0] slope;
	} cfg_t;

	typedef struct packed {
		logic [ANG_OUT_W-1:0] ang;
		fail_t                code;
		logic                 hit;
	} res_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [ANG_W-1:0] root;
	} sq_acc_t;

	// one restoring square-root step: brings in two radicand bits, yields one root bit
	function automatic sq_acc_t sqrt_step(sq_acc_t a, logic [1:0] two);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		sq_acc_t o;
		r = {a.rem[REM_W-3:0], two};
		t = {{(REM_W-ANG_W-2){1'b0}}, a.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {a.root[ANG_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[ANG_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

### src/track_pair_tolerance_match_top.sv
// Top level of the track pair tolerance matcher: ports, registers and pipeline hookup.
//
// Usage:
//   s_* carries one request per track pair (predicted and candidate position and slope).
//   m_* returns one result per request, in order: hit, fail code, track angle.
//   cfg_we/cfg_idx/cfg_data write the eight tolerance registers; change them only
//   while no request is in flight.
// Timing:
//   A request passes from s_tvalid & s_tready to m_tvalid through 4 front stages
//   (differences, products, sums, magnitudes), 10 square-root stages at two
//   root bits each, and 4 limit stages (growth, limit, scaling, compare).
//   Throughput: one request per cycle unless stalled; each stage has its own valid bit.
// Reset:
//   arst_n clears all stage valid bits and loads the register defaults.
// Back-pressure:
//   When m_tready is low the full stages hold; empty stages ahead still fill,
//   so s_tready drops only once every stage holds a request.
module track_pair_tolerance_match_top import tptm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pred_x, pred_y, pred_ax, pred_ay, cand_x, cand_y, cand_ax, cand_ay, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hit, fail_code, track_angle, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t             cfg_q;
	trk_pair_t        trk;
	logic             fr_valid, fr_ready;
	logic [SQ_W-1:0]  fr_sq;
	proj_t            fr_prj;
	logic             sq_valid, sq_ready;
	logic [ANG_W-1:0] sq_ang;
	proj_t            sq_prj;
	res_t             res;

	// tolerance registers, mapped onto test slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base[TST_PL]  <= CFG_W'(480);
			cfg_q.slope[TST_PL] <= CFG_W'(0);
			cfg_q.base[TST_PR]  <= CFG_W'(640);
			cfg_q.slope[TST_PR] <= CFG_W'(480);
			cfg_q.base[TST_AL]  <= CFG_W'(3277);
			cfg_q.slope[TST_AL] <= CFG_W'(0);
			cfg_q.base[TST_AR]  <= CFG_W'(6554);
			cfg_q.slope[TST_AR] <= CFG_W'(6554);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POS_LAT_BASE:  cfg_q.base[TST_PL]  <= cfg_data;
				REG_POS_LAT_SLOPE: cfg_q.slope[TST_PL] <= cfg_data;
				REG_POS_RAD_BASE:  cfg_q.base[TST_PR]  <= cfg_data;
				REG_POS_RAD_SLOPE: cfg_q.slope[TST_PR] <= cfg_data;
				REG_ANG_LAT_BASE:  cfg_q.base[TST_AL]  <= cfg_data;
				REG_ANG_LAT_SLOPE: cfg_q.slope[TST_AL] <= cfg_data;
				REG_ANG_RAD_BASE:  cfg_q.base[TST_AR]  <= cfg_data;
				REG_ANG_RAD_SLOPE: cfg_q.slope[TST_AR] <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the request
	assign trk.pred_x  = s_tdata[22:0];
	assign trk.pred_y  = s_tdata[45:23];
	assign trk.pred_ax = s_tdata[65:46];
	assign trk.pred_ay = s_tdata[85:66];
	assign trk.cand_x  = s_tdata[108:86];
	assign trk.cand_y  = s_tdata[131:109];
	assign trk.cand_ax = s_tdata[151:132];
	assign trk.cand_ay = s_tdata[171:152];

	tptm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_trk    (trk),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_sq    (fr_sq),
		.out_prj   (fr_prj)
	);

	tptm_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_sq     (fr_sq),
		.in_prj    (fr_prj),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_ang   (sq_ang),
		.out_prj   (sq_prj)
	);

	tptm_limit u_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_ang    (sq_ang),
		.in_prj    (sq_prj),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result
	assign m_tdata = {1'b0, res.ang, res.code, res.hit};

endmodule

### src/tptm_front.sv
// Front pipeline: differences, projection products, sums and magnitudes, slope square.
module tptm_front import tptm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  trk_pair_t        in_trk,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SQ_W-1:0]  out_sq,
	output proj_t            out_prj
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [DPOS_W-1:0] dx_s1, dy_s1;
	logic signed [DSLP_W-1:0] dax_s1, day_s1;
	logic signed [SLP_W-1:0]  pax_s1, pay_s1;

	logic signed [PROD_W-1:0]  pxa_s2, pya_s2, pxb_s2, pyb_s2;
	logic signed [APROD_W-1:0] axa_s2, aya_s2, axb_s2, ayb_s2;
	logic signed [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [NTEST-1:0][DPOS_W-1:0] flat_s2, flat_s3;

	logic signed [PROJ_W-1:0]  spr_s3, spl_s3;
	logic signed [APROJ_W-1:0] sar_s3, sal_s3;
	logic [SQ_W-1:0]           sq_s3, sq_s4;
	proj_t                     prj_s4;

	// a stage loads when it is empty or its content moves on
	assign adv4     = ~v_s4 | out_ready;
	assign adv3     = ~v_s3 | adv4;
	assign adv2     = ~v_s2 | adv3;
	assign adv1     = ~v_s1 | adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (adv1) begin
			dx_s1  <= DPOS_W'(in_trk.pred_x) - DPOS_W'(in_trk.cand_x);
			dy_s1  <= DPOS_W'(in_trk.pred_y) - DPOS_W'(in_trk.cand_y);
			dax_s1 <= DSLP_W'(in_trk.pred_ax) - DSLP_W'(in_trk.cand_ax);
			day_s1 <= DSLP_W'(in_trk.pred_ay) - DSLP_W'(in_trk.cand_ay);
			pax_s1 <= in_trk.pred_ax;
			pay_s1 <= in_trk.pred_ay;
		end
	end

	// stage 2: products, squares, raw magnitudes
	always_ff @(posedge clk) begin
		if (adv2) begin
			pxa_s2 <= PROD_W'(dx_s1) * PROD_W'(pax_s1);
			pya_s2 <= PROD_W'(dy_s1) * PROD_W'(pay_s1);
			pxb_s2 <= PROD_W'(dx_s1) * PROD_W'(pay_s1);
			pyb_s2 <= PROD_W'(dy_s1) * PROD_W'(pax_s1);
			axa_s2 <= APROD_W'(dax_s1) * APROD_W'(pax_s1);
			aya_s2 <= APROD_W'(day_s1) * APROD_W'(pay_s1);
			axb_s2 <= APROD_W'(dax_s1) * APROD_W'(pay_s1);
			ayb_s2 <= APROD_W'(day_s1) * APROD_W'(pax_s1);
			sqx_s2 <= SQ_W'(pax_s1) * SQ_W'(pax_s1);
			sqy_s2 <= SQ_W'(pay_s1) * SQ_W'(pay_s1);
			flat_s2[TST_PR] <= dy_s1[DPOS_W-1] ? DPOS_W'(-dy_s1) : DPOS_W'(dy_s1);
			flat_s2[TST_PL] <= dx_s1[DPOS_W-1] ? DPOS_W'(-dx_s1) : DPOS_W'(dx_s1);
			flat_s2[TST_AR] <= DPOS_W'(day_s1[DSLP_W-1] ?
				DSLP_W'(-day_s1) : DSLP_W'(day_s1));
			flat_s2[TST_AL] <= DPOS_W'(dax_s1[DSLP_W-1] ?
				DSLP_W'(-dax_s1) : DSLP_W'(dax_s1));
		end
	end

	// stage 3: radial and lateral sums, slope square sum
	always_ff @(posedge clk) begin
		if (adv3) begin
			spr_s3  <= PROJ_W'(pxa_s2) + PROJ_W'(pya_s2);
			spl_s3  <= PROJ_W'(pxb_s2) - PROJ_W'(pyb_s2);
			sar_s3  <= APROJ_W'(axa_s2) + APROJ_W'(aya_s2);
			sal_s3  <= APROJ_W'(axb_s2) - APROJ_W'(ayb_s2);
			sq_s3   <= $unsigned(sqx_s2) + $unsigned(sqy_s2);
			flat_s3 <= flat_s2;
		end
	end

	// stage 4: magnitudes of the projections
	always_ff @(posedge clk) begin
		if (adv4) begin
			prj_s4.prj[TST_PR] <= spr_s3[PROJ_W-1] ? PROJ_W'(-spr_s3) : PROJ_W'(spr_s3);
			prj_s4.prj[TST_PL] <= spl_s3[PROJ_W-1] ? PROJ_W'(-spl_s3) : PROJ_W'(spl_s3);
			prj_s4.prj[TST_AR] <= PROJ_W'(sar_s3[APROJ_W-1] ?
				APROJ_W'(-sar_s3) : APROJ_W'(sar_s3));
			prj_s4.prj[TST_AL] <= PROJ_W'(sal_s3[APROJ_W-1] ?
				APROJ_W'(-sal_s3) : APROJ_W'(sal_s3));
			prj_s4.flat <= flat_s3;
			sq_s4       <= sq_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_sq    = sq_s4;
	assign out_prj   = prj_s4;

endmodule

### src/tptm_isqrt.sv
// Pipelined integer square root, two root bits per stage, with payload carried alongside.
module tptm_isqrt import tptm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SQ_W-1:0]  in_sq,
	input  proj_t            in_prj,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ANG_W-1:0] out_ang,
	output proj_t            out_prj
);

	logic [SQ_STAGES-1:0] vld_s;
	logic [SQ_STAGES-1:0] vld_in;
	logic [SQ_STAGES:0]   adv;
	sq_acc_t              acc_s  [SQ_STAGES];
	sq_acc_t              acc_in [SQ_STAGES];
	logic [SQ_W-1:0]      sq_s   [SQ_STAGES];
	logic [SQ_W-1:0]      sq_in  [SQ_STAGES];
	proj_t                prj_s  [SQ_STAGES];
	proj_t                prj_in [SQ_STAGES];

	assign adv[SQ_STAGES] = out_ready;
	assign in_ready       = adv[0];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		// stage input comes from the port or the previous stage
		if (g == 0) begin : g_first
			assign vld_in[g] = in_valid;
			assign acc_in[g] = '0;
			assign sq_in[g]  = in_sq;
			assign prj_in[g] = in_prj;
		end else begin : g_next
			assign vld_in[g] = vld_s[g-1];
			assign acc_in[g] = acc_s[g-1];
			assign sq_in[g]  = sq_s[g-1];
			assign prj_in[g] = prj_s[g-1];
		end

		assign adv[g] = ~vld_s[g] | adv[g+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv[g]) begin
				vld_s[g] <= vld_in[g];
			end
		end

		// two root bits from the next four radicand bits
		always_ff @(posedge clk) begin
			if (adv[g]) begin
				acc_s[g] <= sqrt_step(sqrt_step(acc_in[g], sq_in[g][SQ_W-1-4*g -: 2]),
					sq_in[g][SQ_W-3-4*g -: 2]);
				sq_s[g]  <= sq_in[g];
				prj_s[g] <= prj_in[g];
			end
		end
	end

	assign out_valid = vld_s[SQ_STAGES-1];
	assign out_ang   = acc_s[SQ_STAGES-1].root;
	assign out_prj   = prj_s[SQ_STAGES-1];

endmodule

### src/tptm_limit.sv
// Tolerance pipeline: angle-scaled limits, compares and the first failing test.
module tptm_limit import tptm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ANG_W-1:0] in_ang,
	input  proj_t            in_prj,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic [ANG_W-1:0] ang_s1, ang_s2, ang_s3;
	logic             steep_s1, steep_s2, steep_s3;
	proj_t            prj_s1, prj_s2, prj_s3;
	logic [NTEST-1:0][MUL_W-1:0] mul_s1;
	logic [NTEST-1:0][LIM_W-1:0] lim_s2, lim_s3;
	logic [NTEST-1:0][LT_W-1:0]  lt_s3;
	logic [NTEST-1:0]            fail;
	fail_t                       code;
	res_t                        res_s4;

	assign adv4     = ~v_s4 | out_ready;
	assign adv3     = ~v_s3 | adv4;
	assign adv2     = ~v_s2 | adv3;
	assign adv1     = ~v_s1 | adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: growth term slope * angle
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int t = 0; t < NTEST; t++) begin
				mul_s1[t] <= MUL_W'(cfg.slope[t]) * MUL_W'(in_ang);
			end
			ang_s1   <= in_ang;
			steep_s1 <= in_ang > ANGLE_STEEP;
			prj_s1   <= in_prj;
		end
	end

	// stage 2: limit = base + growth / 2^16
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int t = 0; t < NTEST; t++) begin
				lim_s2[t] <= LIM_W'(cfg.base[t]) + LIM_W'(mul_s1[t][MUL_W-1:16]);
			end
			ang_s2   <= ang_s1;
			steep_s2 <= steep_s1;
			prj_s2   <= prj_s1;
		end
	end

	// stage 3: limit scaled by the angle for the projected tests
	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int t = 0; t < NTEST; t++) begin
				lt_s3[t] <= LT_W'(lim_s2[t]) * LT_W'(ang_s2);
			end
			lim_s3   <= lim_s2;
			ang_s3   <= ang_s2;
			steep_s3 <= steep_s2;
			prj_s3   <= prj_s2;
		end
	end

	// compare each test; equal to the limit passes
	always_comb begin
		for (int t = 0; t < NTEST; t++) begin
			if (steep_s3) begin
				fail[t] = prj_s3.prj[t] > PROJ_W'(lt_s3[t]);
			end else begin
				fail[t] = PROJ_W'(prj_s3.flat[t]) > PROJ_W'(lim_s3[t]);
			end
		end
		if (fail[TST_PR]) begin
			code = FAIL_POS_RAD;
		end else if (fail[TST_PL]) begin
			code = FAIL_POS_LAT;
		end else if (fail[TST_AR]) begin
			code = FAIL_ANG_RAD;
		end else if (fail[TST_AL]) begin
			code = FAIL_ANG_LAT;
		end else begin
			code = FAIL_NONE;
		end
	end

	// stage 4: result register, reported angle saturates
	always_ff @(posedge clk) begin
		if (adv4) begin
			res_s4.hit  <= code == FAIL_NONE;
			res_s4.code <= code;
			res_s4.ang  <= ang_s3[ANG_W-1] ? {ANG_OUT_W{1'b1}} : ang_s3[ANG_OUT_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

### src/tptm_checker.sv
// Port-level checks on the matcher's result stream, bound to the top level.
module tptm_checker import tptm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// hit is set exactly when no test failed
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == FAIL_NONE)))
		else $error("hit disagrees with fail code");

	// fail code never beyond the last test, and the pad bit stays clear
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= FAIL_ANG_LAT) && !m_tdata[OUT_DATA_W-1])
		else $error("fail code or pad bit out of range");

	// pipeline is empty right after reset release
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present right after reset");

endmodule

bind track_pair_tolerance_match_top tptm_checker u_tptm_checker (.*);
